// File: hdl/lpi_pkg.sv
package lpi_pkg;

    localparam int COORD_W = 32;
    localparam int DV_W    = COORD_W + 1;   // direction may be a difference of points
    localparam int DMAG_W  = 65;            // |dot(dir, N)| < 3 * 2^63
    localparam int NMAG_W  = 64;            // |num| stays below 2^64
    localparam int WIDE_W  = 66;            // signed dot products and numerator
    localparam int PROD_W  = 96;            // |dir| * |num|
    localparam int QUO_W   = 35;            // quotient bits kept; above that it saturates
    localparam int CMP_W   = PROD_W + 5;    // room for dmag shifted by QUO_W
    localparam int SUM_W   = 37;            // origin plus quotient before the clamp
    localparam int LANES   = 3;

    localparam logic [QUO_W-1:0] QUO_LIMIT = QUO_W'(1) << (QUO_W - 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DEGEN    = 2'd1,
        ST_PARALLEL = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

    // one item on its way through the divider
    typedef struct packed {
        logic [LANES-1:0][PROD_W-1:0]  rem;
        logic [LANES-1:0][QUO_W-1:0]   quo;
        logic [LANES-1:0]              ovf;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][COORD_W-1:0] org;
        logic [DMAG_W-1:0]             dmag;
        status_t                       early;
    } div_t;

endpackage

// File: hdl/lpi_query_if.sv
interface lpi_query_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] first_z;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [31:0] second_z;
    logic [31:0] plane_a;
    logic [31:0] plane_b;
    logic [31:0] plane_c;
    logic [31:0] plane_d;

    modport source (output valid, operation, first_x, first_y, first_z,
                    second_x, second_y, second_z, plane_a, plane_b, plane_c, plane_d,
                    input ready);
    modport sink (input valid, operation, first_x, first_y, first_z,
                  second_x, second_y, second_z, plane_a, plane_b, plane_c, plane_d,
                  output ready);
endinterface

// File: hdl/lpi_result_if.sv
interface lpi_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [31:0] hit_z;
    logic [1:0]  status;

    modport source (output valid, hit_x, hit_y, hit_z, status, input ready);
    modport sink (input valid, hit_x, hit_y, hit_z, status, output ready);
endinterface

// File: hdl/lpi_front.sv
module lpi_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    lpi_query_if.sink         query,
    output logic              vld,
    output lpi_pkg::div_t     data
);

    localparam int L = lpi_pkg::LANES;

    logic [L-1:0][31:0] f_in, s_in, n_in;

    // stage A: origin and direction
    logic                               a_vld_reg;
    logic signed [31:0]                 a_o_reg  [L];
    logic signed [lpi_pkg::DV_W-1:0]    a_dv_reg [L];
    logic signed [31:0]                 a_nv_reg [L];
    logic signed [31:0]                 a_d_reg;
    logic                               a_deg_reg;
    // stage B: products
    logic                               b_vld_reg;
    logic signed [lpi_pkg::DMAG_W-1:0]  b_pd_reg [L];
    logic signed [63:0]                 b_po_reg [L];
    logic signed [lpi_pkg::WIDE_W-1:0]  b_dsh_reg;
    logic signed [31:0]                 b_o_reg  [L];
    logic signed [lpi_pkg::DV_W-1:0]    b_dv_reg [L];
    logic                               b_deg_reg;
    // stage C: sums
    logic                               c_vld_reg;
    logic signed [lpi_pkg::WIDE_W-1:0]  c_den_reg, c_num_reg;
    logic signed [31:0]                 c_o_reg  [L];
    logic signed [lpi_pkg::DV_W-1:0]    c_dv_reg [L];
    logic                               c_deg_reg;
    // stage D: magnitudes and signs
    logic                               d_vld_reg;
    logic [lpi_pkg::DMAG_W-1:0]         d_dmag_reg;
    logic [lpi_pkg::NMAG_W-1:0]         d_nmag_reg;
    logic [lpi_pkg::DV_W-1:0]           d_dvm_reg [L];
    logic [L-1:0]                       d_neg_reg;
    logic signed [31:0]                 d_o_reg  [L];
    lpi_pkg::status_t                   d_early_reg;
    // stage E: partial products
    logic                               e_vld_reg;
    logic [lpi_pkg::DMAG_W-1:0]         e_pl_reg [L], e_ph_reg [L];
    logic [lpi_pkg::DMAG_W-1:0]         e_dmag_reg;
    logic [L-1:0]                       e_neg_reg;
    logic signed [31:0]                 e_o_reg  [L];
    lpi_pkg::status_t                   e_early_reg;
    // stage F: full product
    logic                               f_vld_reg;
    logic [lpi_pkg::PROD_W-1:0]         f_p_reg [L];
    logic [lpi_pkg::DMAG_W-1:0]         f_dmag_reg;
    logic [L-1:0]                       f_neg_reg;
    logic signed [31:0]                 f_o_reg  [L];
    lpi_pkg::status_t                   f_early_reg;
    // stage G: quotient range check
    logic                               g_vld_reg;
    lpi_pkg::div_t                      g_data_reg;

    logic signed [lpi_pkg::WIDE_W-1:0]  den_sum, on_sum;
    logic [lpi_pkg::CMP_W-1:0]          dlim;

    assign query.ready = adv;
    assign f_in = {query.first_z, query.first_y, query.first_x};
    assign s_in = {query.second_z, query.second_y, query.second_x};
    assign n_in = {query.plane_c, query.plane_b, query.plane_a};

    assign den_sum = lpi_pkg::WIDE_W'(b_pd_reg[0]) + lpi_pkg::WIDE_W'(b_pd_reg[1])
                   + lpi_pkg::WIDE_W'(b_pd_reg[2]);
    assign on_sum  = lpi_pkg::WIDE_W'(b_po_reg[0]) + lpi_pkg::WIDE_W'(b_po_reg[1])
                   + lpi_pkg::WIDE_W'(b_po_reg[2]) + b_dsh_reg;
    assign dlim    = lpi_pkg::CMP_W'(f_dmag_reg) << lpi_pkg::QUO_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= query.valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < L; i++)
            begin
                if (query.operation)
                begin
                    a_o_reg[i]  <= $signed(s_in[i]);
                    a_dv_reg[i] <= lpi_pkg::DV_W'($signed(s_in[i]))
                                 - lpi_pkg::DV_W'($signed(f_in[i]));
                end
                else
                begin
                    a_o_reg[i]  <= $signed(f_in[i]);
                    a_dv_reg[i] <= lpi_pkg::DV_W'($signed(s_in[i]));
                end
                a_nv_reg[i] <= $signed(n_in[i]);

                b_pd_reg[i] <= lpi_pkg::DMAG_W'(a_dv_reg[i]) * lpi_pkg::DMAG_W'(a_nv_reg[i]);
                b_po_reg[i] <= 64'(a_o_reg[i]) * 64'(a_nv_reg[i]);
                b_o_reg[i]  <= a_o_reg[i];
                b_dv_reg[i] <= a_dv_reg[i];

                c_o_reg[i]  <= b_o_reg[i];
                c_dv_reg[i] <= b_dv_reg[i];

                d_dvm_reg[i] <= c_dv_reg[i][lpi_pkg::DV_W-1] ? lpi_pkg::DV_W'(-c_dv_reg[i])
                                                             : lpi_pkg::DV_W'(c_dv_reg[i]);
                d_neg_reg[i] <= c_dv_reg[i][lpi_pkg::DV_W-1]
                              ^ c_num_reg[lpi_pkg::WIDE_W-1] ^ c_den_reg[lpi_pkg::WIDE_W-1];
                d_o_reg[i]   <= c_o_reg[i];

                e_pl_reg[i] <= lpi_pkg::DMAG_W'(d_dvm_reg[i]) * lpi_pkg::DMAG_W'(d_nmag_reg[31:0]);
                e_ph_reg[i] <= lpi_pkg::DMAG_W'(d_dvm_reg[i]) * lpi_pkg::DMAG_W'(d_nmag_reg[63:32]);
                e_o_reg[i]  <= d_o_reg[i];

                f_p_reg[i] <= lpi_pkg::PROD_W'(e_pl_reg[i]) + (lpi_pkg::PROD_W'(e_ph_reg[i]) << 32);
                f_o_reg[i] <= e_o_reg[i];

                g_data_reg.rem[i] <= f_p_reg[i];
                g_data_reg.quo[i] <= '0;
                g_data_reg.ovf[i] <= lpi_pkg::CMP_W'(f_p_reg[i]) >= dlim;
                g_data_reg.org[i] <= f_o_reg[i];
            end
            a_d_reg   <= $signed(query.plane_d);
            a_deg_reg <= (query.plane_a == '0) && (query.plane_b == '0) && (query.plane_c == '0);

            b_dsh_reg <= lpi_pkg::WIDE_W'(a_d_reg) <<< FRAC_BITS;
            b_deg_reg <= a_deg_reg;

            c_den_reg <= den_sum;
            c_num_reg <= -on_sum;
            c_deg_reg <= b_deg_reg;

            d_dmag_reg <= c_den_reg[lpi_pkg::WIDE_W-1] ? lpi_pkg::DMAG_W'(-c_den_reg)
                                                       : lpi_pkg::DMAG_W'(c_den_reg);
            d_nmag_reg <= c_num_reg[lpi_pkg::WIDE_W-1] ? lpi_pkg::NMAG_W'(-c_num_reg)
                                                       : lpi_pkg::NMAG_W'(c_num_reg);
            if (c_deg_reg)
                d_early_reg <= lpi_pkg::ST_DEGEN;
            else if (c_den_reg == '0)
                d_early_reg <= lpi_pkg::ST_PARALLEL;
            else
                d_early_reg <= lpi_pkg::ST_OK;

            e_dmag_reg  <= d_dmag_reg;
            e_neg_reg   <= d_neg_reg;
            e_early_reg <= d_early_reg;

            f_dmag_reg  <= e_dmag_reg;
            f_neg_reg   <= e_neg_reg;
            f_early_reg <= e_early_reg;

            g_data_reg.neg   <= f_neg_reg;
            g_data_reg.dmag  <= f_dmag_reg;
            g_data_reg.early <= f_early_reg;
        end
    end

    assign vld  = g_vld_reg;
    assign data = g_data_reg;

endmodule

// File: hdl/lpi_div_step.sv
module lpi_div_step #(
    parameter int BIT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  lpi_pkg::div_t     in_data,
    output logic              vld,
    output lpi_pkg::div_t     data
);

    logic                      vld_reg;
    lpi_pkg::div_t             data_reg, data_next;
    logic [lpi_pkg::CMP_W-1:0] dsh;
    logic [lpi_pkg::CMP_W-1:0] diff [lpi_pkg::LANES];

    assign dsh = lpi_pkg::CMP_W'(in_data.dmag) << BIT;

    // one restoring step on each lane
    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < lpi_pkg::LANES; i++)
        begin
            diff[i] = lpi_pkg::CMP_W'(in_data.rem[i]) - dsh;
            if (lpi_pkg::CMP_W'(in_data.rem[i]) >= dsh)
            begin
                data_next.rem[i]      = diff[i][lpi_pkg::PROD_W-1:0];
                data_next.quo[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign vld  = vld_reg;
    assign data = data_reg;

endmodule

// File: hdl/lpi_back.sv
module lpi_back (
    input  logic              clk,
    input  logic              rst_n,
    output logic              adv,
    input  logic              in_vld,
    input  lpi_pkg::div_t     in_data,
    lpi_result_if.source      result
);

    localparam int L = lpi_pkg::LANES;
    localparam logic signed [lpi_pkg::SUM_W-1:0] MAX_V = lpi_pkg::SUM_W'(32'sh7fffffff);
    localparam logic signed [lpi_pkg::SUM_W-1:0] MIN_V = -lpi_pkg::SUM_W'(33'sh080000000);

    logic                  out_vld_reg;
    logic [L-1:0][31:0]    hit_reg, hit_next;
    lpi_pkg::status_t      status_reg, status_next;

    logic signed [lpi_pkg::SUM_W-1:0] q_ext [L];
    logic signed [lpi_pkg::SUM_W-1:0] sum   [L];
    logic [L-1:0]                     sat;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            q_ext[i] = $signed(lpi_pkg::SUM_W'(in_data.quo[i]));
            sum[i]   = in_data.neg[i]
                     ? lpi_pkg::SUM_W'($signed(in_data.org[i])) - q_ext[i]
                     : lpi_pkg::SUM_W'($signed(in_data.org[i])) + q_ext[i];
            if (in_data.ovf[i] || in_data.quo[i] > lpi_pkg::QUO_LIMIT)
            begin
                sat[i]      = 1'b1;
                hit_next[i] = in_data.neg[i] ? 32'h80000000 : 32'h7fffffff;
            end
            else if (sum[i] > MAX_V)
            begin
                sat[i]      = 1'b1;
                hit_next[i] = 32'h7fffffff;
            end
            else if (sum[i] < MIN_V)
            begin
                sat[i]      = 1'b1;
                hit_next[i] = 32'h80000000;
            end
            else
            begin
                sat[i]      = 1'b0;
                hit_next[i] = sum[i][31:0];
            end
        end
        if (in_data.early != lpi_pkg::ST_OK)
        begin
            hit_next    = '0;
            status_next = in_data.early;
        end
        else
            status_next = (sat != '0) ? lpi_pkg::ST_SAT : lpi_pkg::ST_OK;
    end

    // output register frees the pipe whenever it is empty or being drained
    assign adv = !out_vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    assign result.valid  = out_vld_reg;
    assign result.hit_x  = hit_reg[0];
    assign result.hit_y  = hit_reg[1];
    assign result.hit_z  = hit_reg[2];
    assign result.status = status_reg;

endmodule

// File: hdl/line_plane_intersection_unit.sv
// Throughput: one query per cycle unless a result held at the output stalls the pipe.
// A query passes seven setup stages (origin and direction, products, sums,
// magnitudes, the 33x64 product split in two halves, range check), a
// 35-stage restoring divider at one quotient bit per stage, one output register.
// Reset (rst_n, asynchronous, active low) empties every stage's valid bit.
module line_plane_intersection_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    lpi_query_if.sink    query,
    lpi_result_if.source result
);

    localparam int STEPS = lpi_pkg::QUO_W;

    logic          adv;
    logic          st_vld  [STEPS+1];
    lpi_pkg::div_t st_data [STEPS+1];

    lpi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .query (query),
        .vld   (st_vld[0]),
        .data  (st_data[0])
    );

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        lpi_div_step #(
            .BIT (STEPS - 1 - k)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (st_vld[k]),
            .in_data (st_data[k]),
            .vld     (st_vld[k+1]),
            .data    (st_data[k+1])
        );
    end

    lpi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (st_vld[STEPS]),
        .in_data (st_data[STEPS]),
        .result  (result)
    );

endmodule
